### rtl/core/slid_pkg.sv
`timescale 1ns / 1ps

package slid_pkg;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEFAULT       = 16;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  // Operation codes carried on s_tuser
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
  localparam logic [OP_W-1:0] OP_REWIND = 3'd3;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd4;

  // Status codes carried on m_tuser
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_PAST_END  = 2'd3;

  // Shift commands broadcast to every cell
  typedef struct packed {
    logic ins;  // open a slot and shift the tail up
    logic del;  // close the matched slot and shift the tail down
  } slid_op_t;

endpackage

### rtl/core/slid_cell.sv
`timescale 1ns / 1ps

module slid_cell #(
  parameter int VALUE_WIDTH = slid_pkg::VALUE_WIDTH_DEFAULT,
  parameter int CNT_W       = 5,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  slid_pkg::slid_op_t     op,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [CNT_W-1:0]       count,
  input  logic [VALUE_WIDTH-1:0] prev_entry,
  input  logic                   prev_after,
  input  logic [VALUE_WIDTH-1:0] next_entry,
  output logic [VALUE_WIDTH-1:0] entry,
  output logic                   after,
  output logic                   eq
);

  logic occupied;
  logic tail;
  logic next_occupied;
  logic ge;

  // Position of this cell relative to the fill level
  assign occupied      = CNT_W'(INDEX) < count;
  assign tail          = count == CNT_W'(INDEX);
  assign next_occupied = CNT_W'(INDEX + 1) < count;

  // Local compares; the list is sorted, so ge is a contiguous run to the top
  assign ge    = occupied && ($signed(entry) >= $signed(value));
  assign eq    = occupied && (entry == value);
  assign after = ge || tail;

  // Insert: first cell of the run takes the new value, the rest take the lower neighbor.
  // Delete: cells from the match up take the upper neighbor.
  always_ff @(posedge clk) begin
    if (op.ins && after) begin
      entry <= prev_after ? prev_entry : value;
    end else if (op.del && ge && next_occupied) begin
      entry <= next_entry;
    end
  end

endmodule

### rtl/core/sorted_list_insert_delete.sv
`timescale 1ns / 1ps

// Sorted list of up to DEPTH signed values, kept in ascending order.
// Input channel s_*: one transaction is one operation. s_tuser carries the
// operation (insert, delete, clear, rewind cursor, read next), s_tdata the value.
// Output channel m_*: exactly one result transaction per operation, with the
// status on m_tuser and the read value, entry count and full flag on m_tdata.
// An accepted operation's result is registered and is on m_* in the next cycle.
// Throughput is one operation per cycle while m_tready keeps up: each entry sits
// in its own cell, and every cell compares against the value and loads from a
// neighbor in the same cycle, so an insert or delete shifts the whole row at
// once. Deleting relies on an OR across all cells to see if any entry matched.
// The result register holds its transaction while m_tready is low; s_tready is
// high whenever that register is empty or being taken, so a stalled receiver
// stalls the input after one pending result.
// Reset (rst, synchronous) empties the list, rewinds the read cursor and drops
// any pending result. The stored values themselves are not cleared; only
// positions below the entry count are ever read.
module sorted_list_insert_delete #(
  parameter int DEPTH       = slid_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = slid_pkg::VALUE_WIDTH_DEFAULT,
  localparam int CNT_W      = $clog2(DEPTH + 1),
  localparam int IN_W       = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_BITS   = VALUE_WIDTH + CNT_W + 1,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [IN_W-1:0]               s_tdata,  // value
  input  logic [slid_pkg::OP_W-1:0]     s_tuser,  // operation
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [OUT_W-1:0]              m_tdata,  // read_value, entry_count, is_full
  output logic [slid_pkg::STATUS_W-1:0] m_tuser   // status
);

  localparam int IDX_W = $clog2(DEPTH);

  logic                          s_fire;
  logic [VALUE_WIDTH-1:0]        value;
  logic [slid_pkg::OP_W-1:0]     operation;
  slid_pkg::slid_op_t            cell_op;

  logic [VALUE_WIDTH-1:0]        cell_entry [DEPTH];
  logic [DEPTH-1:0]              cell_after;
  logic [DEPTH-1:0]              cell_eq;
  logic                          found;
  logic                          full;
  logic                          can_read;
  logic [VALUE_WIDTH-1:0]        cursor_entry;

  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_next;
  logic [CNT_W-1:0]              cursor;
  logic [CNT_W-1:0]              cursor_next;
  logic                          out_valid;
  logic [VALUE_WIDTH-1:0]        out_value;
  logic [VALUE_WIDTH-1:0]        out_value_next;
  logic [slid_pkg::STATUS_W-1:0] out_status;
  logic [slid_pkg::STATUS_W-1:0] out_status_next;

  assign s_tready  = !out_valid || m_tready;
  assign s_fire    = s_tvalid && s_tready;
  assign value     = s_tdata[VALUE_WIDTH-1:0];
  assign operation = s_tuser;

  assign found    = |cell_eq;
  assign full     = count == CNT_W'(DEPTH);
  assign can_read = cursor < count;

  // Shift commands for the cell row
  assign cell_op.ins = s_fire && (operation == slid_pkg::OP_INSERT) && !full;
  assign cell_op.del = s_fire && (operation == slid_pkg::OP_DELETE) && found;

  // Row of cells, each linked to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_entry;
    logic                   prev_after;
    logic [VALUE_WIDTH-1:0] next_entry;

    if (i == 0) begin : g_first
      assign prev_entry = '0;
      assign prev_after = 1'b0;
    end else begin : g_inner
      assign prev_entry = cell_entry[i-1];
      assign prev_after = cell_after[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_entry = cell_entry[i];
    end else begin : g_below
      assign next_entry = cell_entry[i+1];
    end

    slid_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CNT_W       (CNT_W),
      .INDEX       (i)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op),
      .value      (value),
      .count      (count),
      .prev_entry (prev_entry),
      .prev_after (prev_after),
      .next_entry (next_entry),
      .entry      (cell_entry[i]),
      .after      (cell_after[i]),
      .eq         (cell_eq[i])
    );
  end

  // Entry under the read cursor; only used while cursor < count
  assign cursor_entry = cell_entry[cursor[IDX_W-1:0]];

  // Next count, cursor and result
  always_comb begin
    count_next      = count;
    cursor_next     = cursor;
    out_value_next  = '0;
    out_status_next = slid_pkg::ST_OK;
    unique case (operation)
      slid_pkg::OP_INSERT: begin
        if (full) begin
          out_status_next = slid_pkg::ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      slid_pkg::OP_DELETE: begin
        if (found) begin
          count_next = count - CNT_W'(1);
        end else begin
          out_status_next = slid_pkg::ST_NOT_FOUND;
        end
      end
      slid_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      slid_pkg::OP_REWIND: begin
        cursor_next = '0;
      end
      slid_pkg::OP_NEXT: begin
        if (can_read) begin
          out_value_next = cursor_entry;
          cursor_next    = cursor + CNT_W'(1);
        end else begin
          out_status_next = slid_pkg::ST_PAST_END;
        end
      end
      default: begin
      end
    endcase
  end

  // List control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s_fire) begin
        count     <= count_next;
        cursor    <= cursor_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      out_value  <= out_value_next;
      out_status <= out_status_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = OUT_W'({full, count, out_value});

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor <= CNT_W'(DEPTH))
    else $error("read cursor above capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> m_tvalid)
    else $error("accepted operation produced no result");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cell_op.ins |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == slid_pkg::ST_FULL) |-> full)
    else $error("full status reported on a list that is not full");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import slid_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int VW = VALUE_WIDTH_DEFAULT;
  localparam int OUT_W = 40;
  localparam int N_ITEMS = 1750;
  localparam int MAX_GAP = 17;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_EVERY = 250;
  localparam int ERR_PRINT_MAX = 40;
  localparam logic [OP_W-1:0] OP_MAX = {OP_W{1'b1}};
  localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};

  // One operation as offered on the input side
  typedef struct {
    logic [OP_W-1:0] op;
    logic [VW-1:0]   value;
    int              gap;
    bit              drain;
  } list_op_t;

  // One result transaction, field by field
  typedef struct packed {
    logic [VW-1:0]       read_value;
    logic [STATUS_W-1:0] status;
    logic [4:0]          entry_count;
    logic                is_full;
  } list_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [VW-1:0]       s_tdata = '0;   // value
  logic [OP_W-1:0]     s_tuser = '0;   // operation
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;        // read_value, entry_count, is_full
  logic [STATUS_W-1:0] m_tuser;        // status

  sorted_list_insert_delete dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Predictor state: the sorted store, its fill level and the read cursor
  logic signed [VW-1:0] sorted_vals [DEPTH];
  int                   n_stored = 0;
  int                   rd_ptr = 0;

  list_op_t     list_ops [$];
  list_result_t pending_results [$];

  int  err_cnt = 0;
  int  in_cnt = 0;
  int  done_cnt = 0;
  bit  all_sent = 1'b0;
  bit  rx_hold = 1'b0;
  int  cycle_cnt = 0;

  // Stimulus generator state
  int             n_items = 0;
  bit             calm = 1'b0;
  bit             drain_next = 1'b0;
  logic [VW-1:0]  recent [16];
  int             recent_idx = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < ERR_PRINT_MAX) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    err_cnt++;
  endtask

  // Apply one operation to the predicted list and return its result
  function automatic list_result_t apply_op(input logic [OP_W-1:0] op,
                                            input logic signed [VW-1:0] val);
    list_result_t r;
    int pos;
    int i;
    bit found;
    r = '0;
    r.status = ST_OK;
    found = 1'b0;
    case (op)
      OP_INSERT: begin
        if (n_stored >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // new value goes ahead of the first entry >= it
          pos = n_stored;
          for (i = 0; i < n_stored; i++) begin
            if (!found && val <= sorted_vals[i]) begin
              pos = i;
              found = 1'b1;
            end
          end
          for (i = n_stored; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
          sorted_vals[pos] = val;
          n_stored++;
        end
      end
      OP_DELETE: begin
        pos = n_stored;
        for (i = 0; i < n_stored; i++) begin
          if (!found && sorted_vals[i] == val) begin
            pos = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (i = pos; i + 1 < n_stored; i++) sorted_vals[i] = sorted_vals[i+1];
          n_stored--;
        end
      end
      OP_CLEAR: n_stored = 0;
      OP_REWIND: rd_ptr = 0;
      OP_NEXT: begin
        // cursor survives edits, so it is checked against the count here
        if (rd_ptr >= n_stored) begin
          r.status = ST_PAST_END;
        end else begin
          r.read_value = sorted_vals[rd_ptr];
          rd_ptr++;
        end
      end
      default: ;
    endcase
    r.entry_count = n_stored[4:0];
    r.is_full = (n_stored == DEPTH);
    return r;
  endfunction

  // Mostly a narrow band around zero so duplicates and matches are common
  function automatic logic [VW-1:0] pick_value();
    int sel;
    logic [VW-1:0] v;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      v = $signed($urandom_range(0, 16)) - 8;
    end else if (sel == 5) begin
      case ($urandom_range(0, 3))
        0: v = VAL_MIN;
        1: v = VAL_MAX;
        2: v = '0;
        default: v = '1;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  task automatic add_op(input logic [OP_W-1:0] op, input logic [VW-1:0] value);
    list_op_t it;
    it.op = op;
    it.value = value;
    it.gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    it.drain = drain_next;
    drain_next = 1'b0;
    list_ops.push_back(it);
    if (op <= OP_NEXT) n_items++;
    if (op == OP_INSERT) begin
      recent[recent_idx] = value;
      recent_idx = (recent_idx + 1) % 16;
    end
  endtask

  function automatic logic [VW-1:0] pick_victim();
    if ($urandom_range(0, 4) != 0) return recent[$urandom_range(0, 15)];
    return pick_value();
  endfunction

  // Build the whole stimulus, then release reset and wait for the end
  initial begin
    int last_drain;
    int n;
    int i;
    logic [OP_W-1:0] op;
    for (i = 0; i < 16; i++) recent[i] = '0;
    for (i = 0; i < DEPTH; i++) sorted_vals[i] = '0;

    // directed: empty list cases, extremes, duplicates, reads, unused codes
    add_op(OP_NEXT, $urandom);
    add_op(OP_DELETE, '0);
    add_op(OP_INSERT, VAL_MAX);
    add_op(OP_INSERT, VAL_MIN);
    add_op(OP_INSERT, '0);
    add_op(OP_INSERT, '1);
    add_op(OP_INSERT, '0);
    add_op(OP_REWIND, $urandom);
    add_op(OP_NEXT, $urandom);
    add_op(OP_NEXT, $urandom);
    add_op(OP_NEXT, $urandom);
    add_op(OP_DELETE, '0);
    add_op(OP_DELETE, VW'(5));
    add_op(OP_INSERT, VAL_MAX);
    add_op(OP_NEXT, $urandom);
    add_op(OP_NEXT, $urandom);
    add_op(OP_NEXT, $urandom);
    add_op(OP_NEXT, $urandom);
    add_op(OP_NEXT, $urandom);
    for (op = OP_W'(OP_NEXT + 1); op != 0; op++) add_op(op, $urandom);
    add_op(OP_CLEAR, $urandom);
    add_op(OP_NEXT, $urandom);

    // random sequences, with a full drain now and then
    drain_next = 1'b1;
    last_drain = n_items;
    while (n_items < N_ITEMS) begin
      if ($urandom_range(0, 3) == 0) calm = !calm;
      if (n_items - last_drain >= DRAIN_EVERY) begin
        drain_next = 1'b1;
        last_drain = n_items;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          // fill toward capacity and often push past it
          if ($urandom_range(0, 1)) add_op(OP_CLEAR, $urandom);
          n = $urandom_range(14, 20);
          for (i = 0; i < n; i++) add_op(OP_INSERT, pick_value());
        end
        2, 3: begin
          // sweep the cursor, often beyond the end
          add_op(OP_REWIND, $urandom);
          n = $urandom_range(1, 20);
          for (i = 0; i < n; i++) add_op(OP_NEXT, $urandom);
        end
        4, 5: begin
          n = $urandom_range(1, 8);
          for (i = 0; i < n; i++) add_op(OP_DELETE, pick_victim());
        end
        6: begin
          add_op(OP_CLEAR, $urandom);
          if ($urandom_range(0, 1)) add_op(OP_REWIND, $urandom);
        end
        7, 8: begin
          n = $urandom_range(1, 10);
          for (i = 0; i < n; i++) begin
            op = OP_W'($urandom_range(0, OP_NEXT));
            if (op == OP_DELETE) add_op(op, pick_victim());
            else add_op(op, pick_value());
          end
        end
        default: begin
          add_op(OP_W'($urandom_range(OP_NEXT + 1, OP_MAX)), $urandom);
        end
      endcase
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (!(all_sent && in_cnt == done_cnt));
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));
    end
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Driver: offers queued operations with their own idle gaps
  int       gap_cnt = 0;
  int       sent_cnt = 0;
  bit       next_valid;
  list_op_t nxt;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
      gap_cnt = 0;
    end else begin
      if (s_tvalid && s_tready) sent_cnt++;
      next_valid = s_tvalid && !s_tready;
      if (!s_tvalid || s_tready) begin
        if (list_ops.size() == 0) begin
          next_valid = 1'b0;
        end else if (gap_cnt < list_ops[0].gap) begin
          gap_cnt++;
        end else if (list_ops[0].drain && sent_cnt != done_cnt) begin
          // hold until every outstanding result is back
        end else begin
          nxt = list_ops.pop_front();
          s_tdata <= nxt.value;
          s_tuser <= nxt.op;
          next_valid = 1'b1;
          gap_cnt = 0;
        end
      end
      s_tvalid <= next_valid;
      all_sent <= (list_ops.size() == 0) && !next_valid;
    end
  end

  // Receiver: per-result stall, with calm stretches and an external hold
  int rx_wait = 0;
  int rx_goal = 0;
  bit rx_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        rx_wait = 0;
        rx_goal = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (rx_hold) begin
        m_tready <= 1'b0;
      end else if (rx_wait >= rx_goal) begin
        m_tready <= 1'b1;
      end else begin
        if (m_tvalid) rx_wait++;
        m_tready <= 1'b0;
      end
    end
  end

  // Long receiver hold-off so the result register fills and s_tready drops
  initial begin
    wait (in_cnt >= 500);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Monitor: checks results first, then predicts for the accepted operation
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.read_value = m_tdata[VW-1:0];
        got.entry_count = m_tdata[VW+4:VW];
        got.is_full = m_tdata[VW+5];
        got.status = m_tuser;
        if (pending_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %0d want %0d",
                                      $signed(got.read_value), $signed(want.read_value)));
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
          if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      got.entry_count, want.entry_count));
          if (got.is_full !== want.is_full)
            report_mismatch($sformatf("is_full got %0b want %0b", got.is_full, want.is_full));
        end
        done_cnt <= done_cnt + 1;
      end
      if (s_tvalid && s_tready) begin
        pending_results.push_back(apply_op(s_tuser, s_tdata));
        in_cnt <= in_cnt + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
